[sv/cir_pkg.sv]
// Shared types and constants for the coprocessor interface register block.
package cir_pkg;

   // Register unit codes carried in the unit field.
   typedef enum logic [2:0] {
      UNIT_MI    = 3'd0,
      UNIT_VI    = 3'd1,
      UNIT_AI    = 3'd2,
      UNIT_PI    = 3'd3,
      UNIT_SP    = 3'd4,
      UNIT_SPPC  = 3'd5,
      UNIT_SI    = 3'd6,
      UNIT_RDRAM = 3'd7
   } unit_type;

   // Word indices within the units.
   localparam logic [5:0] IDX_MI_INIT    = 6'd0;
   localparam logic [5:0] IDX_MI_INTR    = 6'd2;
   localparam logic [5:0] IDX_MI_MASK    = 6'd3;
   localparam logic [5:0] IDX_VI_CURRENT = 6'd4;
   localparam logic [5:0] IDX_AI_STATUS  = 6'd3;
   localparam logic [5:0] IDX_SI_STATUS  = 6'd6;
   localparam logic [5:0] IDX_PI_DRAM    = 6'd0;
   localparam logic [5:0] IDX_PI_CART    = 6'd1;
   localparam logic [5:0] IDX_PI_LENGTH  = 6'd3;
   localparam logic [5:0] IDX_PI_STATUS  = 6'd4;
   localparam logic [5:0] IDX_SP_STATUS  = 6'd4;
   localparam logic [5:0] IDX_SP_DMAFULL = 6'd5;
   localparam logic [5:0] IDX_SP_DMABUSY = 6'd6;
   localparam logic [5:0] IDX_SP_SEMA    = 6'd7;
   localparam logic [5:0] IDX_SP_PC      = 6'd0;

   // Interrupt bit positions in the pending and mask words.
   localparam int INTR_SP = 0;
   localparam int INTR_SI = 1;
   localparam int INTR_AI = 2;
   localparam int INTR_VI = 3;
   localparam int INTR_PI = 4;
   localparam int INTR_DP = 5;

   // Init mode word bit positions.
   localparam int INIT_MODE_BIT  = 7;
   localparam int EBUS_TEST_BIT  = 8;
   localparam int RDRAM_REG_BIT  = 9;

   localparam logic [3:0] WORD_SIZE = 4'd4;
   localparam logic       MODE_READ = 1'b0;

   typedef struct packed {
      logic        mode;
      logic [2:0]  unit;
      logic [7:0]  offset;
      logic [3:0]  access_size;
      logic [31:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic        fall_through;
      logic [31:0] read_data;
      logic        clear_cpu_mi_cause;
      logic [5:0]  pending_bits;
      logic [5:0]  mask_bits;
      logic        sp_halted;
      logic        dma_start;
      logic [31:0] dma_cart_addr;
      logic [23:0] dma_dram_addr;
      logic [24:0] dma_length;
      logic        bad_access;
   } rsp_word_type;

endpackage

[sv/cir_channels.sv]
// Valid/ready channel interfaces for bus access words and result words.
interface cir_req_if;
   import cir_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface cir_rsp_if;
   import cir_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[sv/coprocessor_interface_registers_top.sv]
// Interface and signal processor status register block, one bus access per word.
// The result word is registered and appears in the cycle after the access word is accepted.
// Throughput: one access word per cycle; the result register frees itself when taken,
// so a new word is accepted whenever the result register is empty or being read.
// Reset clears all held registers and flags to zero and empties the result register.
module coprocessor_interface_registers_top (
   input logic   clock,
   input logic   reset,
   cir_req_if.sink   req_chan,
   cir_rsp_if.source rsp_chan
);
   import cir_pkg::*;

   // Held register state.
   logic [9:0]  init_mode_ff, init_mode_in;
   logic [5:0]  pending_ff, pending_in;
   logic [5:0]  mask_ff, mask_in;
   logic [14:0] sp_status_ff, sp_status_in;
   logic        sema_ff, sema_in;
   logic [11:0] sp_pc_ff, sp_pc_in;
   logic [23:0] pi_dram_ff, pi_dram_in;
   logic [31:0] pi_cart_ff, pi_cart_in;

   // Result register.
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        is_word;
   logic        is_write;
   logic [5:0]  idx;
   logic [31:0] wdata;
   unit_type    unit;

   // A word is taken whenever the result register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_word  = (req_chan.data.access_size == WORD_SIZE) &&
                     (req_chan.data.offset[1:0] == 2'b00);
   assign is_write = req_chan.data.mode;
   assign idx      = req_chan.data.offset[7:2];
   assign wdata    = req_chan.data.write_data;
   assign unit     = unit_type'(req_chan.data.unit);

   // Register rules for the addressed unit.
   always_comb begin
      init_mode_in = init_mode_ff;
      pending_in   = pending_ff;
      mask_in      = mask_ff;
      sp_status_in = sp_status_ff;
      sema_in      = sema_ff;
      sp_pc_in     = sp_pc_ff;
      pi_dram_in   = pi_dram_ff;
      pi_cart_in   = pi_cart_ff;
      rsp_data_in  = '0;
      rsp_data_in.fall_through = 1'b1;

      case (unit)
         UNIT_MI: begin
            if (!is_word) begin
               rsp_data_in.bad_access   = 1'b1;
               rsp_data_in.fall_through = !is_write;
            end else if (is_write) begin
               rsp_data_in.fall_through = 1'b0;
               if (idx == IDX_MI_INIT) begin
                  init_mode_in[6:0] = wdata[6:0];
                  if (wdata[7])  init_mode_in[INIT_MODE_BIT] = 1'b0;
                  if (wdata[8])  init_mode_in[INIT_MODE_BIT] = 1'b1;
                  if (wdata[9])  init_mode_in[EBUS_TEST_BIT] = 1'b0;
                  if (wdata[10]) init_mode_in[EBUS_TEST_BIT] = 1'b1;
                  if (wdata[11]) pending_in[INTR_DP] = 1'b0;
                  if (wdata[12]) init_mode_in[RDRAM_REG_BIT] = 1'b0;
                  if (wdata[13]) init_mode_in[RDRAM_REG_BIT] = 1'b1;
               end else if (idx == IDX_MI_MASK) begin
                  // Clear and set bit pairs, set wins.
                  for (int k = 0; k < 6; k++) begin
                     if (wdata[2*k])   mask_in[k] = 1'b0;
                     if (wdata[2*k+1]) mask_in[k] = 1'b1;
                  end
                  rsp_data_in.clear_cpu_mi_cause = 1'b1;
               end
            end else begin
               if (idx == IDX_MI_INIT) begin
                  rsp_data_in.fall_through = 1'b0;
                  rsp_data_in.read_data    = {22'd0, init_mode_ff};
               end else if (idx == IDX_MI_INTR) begin
                  rsp_data_in.fall_through = 1'b0;
                  rsp_data_in.read_data    = {26'd0, pending_ff};
               end else if (idx == IDX_MI_MASK) begin
                  rsp_data_in.fall_through = 1'b0;
                  rsp_data_in.read_data    = {26'd0, mask_ff};
               end
            end
         end
         UNIT_VI: begin
            if (is_word && is_write && idx == IDX_VI_CURRENT) begin
               pending_in[INTR_VI]      = 1'b0;
               rsp_data_in.fall_through = 1'b0;
            end
         end
         UNIT_AI: begin
            if (is_word && is_write && idx == IDX_AI_STATUS) begin
               pending_in[INTR_AI]      = 1'b0;
               rsp_data_in.fall_through = 1'b0;
            end
         end
         UNIT_PI: begin
            if (!is_word) begin
               rsp_data_in.bad_access   = 1'b1;
               rsp_data_in.fall_through = !is_write;
            end else if (is_write) begin
               if (idx == IDX_PI_DRAM) begin
                  pi_dram_in = wdata[23:0];
               end else if (idx == IDX_PI_CART) begin
                  pi_cart_in = wdata;
               end else if (idx == IDX_PI_LENGTH) begin
                  rsp_data_in.dma_start  = 1'b1;
                  rsp_data_in.dma_length = {1'b0, wdata[23:0]} + 25'd1;
               end else if (idx == IDX_PI_STATUS) begin
                  if (wdata[1]) pending_in[INTR_PI] = 1'b0;
                  rsp_data_in.fall_through = 1'b0;
               end
            end else begin
               if (idx == IDX_PI_DRAM) begin
                  rsp_data_in.fall_through = 1'b0;
                  rsp_data_in.read_data    = {8'd0, pi_dram_ff};
               end else if (idx == IDX_PI_CART) begin
                  rsp_data_in.fall_through = 1'b0;
                  rsp_data_in.read_data    = pi_cart_ff;
               end
            end
         end
         UNIT_SP: begin
            if (!is_word) begin
               rsp_data_in.bad_access = 1'b1;
            end else if (is_write) begin
               if (idx == IDX_SP_STATUS) begin
                  // Halt pair, broke clear, SP interrupt pair, then ten flag pairs.
                  if (wdata[0]) sp_status_in[0] = 1'b0;
                  if (wdata[1]) sp_status_in[0] = 1'b1;
                  if (wdata[2]) sp_status_in[1] = 1'b0;
                  if (wdata[3]) pending_in[INTR_SP] = 1'b0;
                  if (wdata[4]) pending_in[INTR_SP] = 1'b1;
                  for (int k = 0; k < 10; k++) begin
                     if (wdata[5+2*k]) sp_status_in[5+k] = 1'b0;
                     if (wdata[6+2*k]) sp_status_in[5+k] = 1'b1;
                  end
                  rsp_data_in.fall_through = 1'b0;
               end else if (idx == IDX_SP_DMAFULL || idx == IDX_SP_DMABUSY) begin
                  rsp_data_in.fall_through = 1'b0;
               end else if (idx == IDX_SP_SEMA) begin
                  sema_in = 1'b0;
               end
            end else begin
               if (idx == IDX_SP_STATUS) begin
                  rsp_data_in.fall_through = 1'b0;
                  rsp_data_in.read_data    = {17'd0, sp_status_ff};
               end else if (idx == IDX_SP_SEMA) begin
                  // Test and set: return the old flag, leave it taken.
                  rsp_data_in.fall_through = 1'b0;
                  rsp_data_in.read_data    = {31'd0, sema_ff};
                  sema_in = 1'b1;
               end
            end
         end
         UNIT_SPPC: begin
            if (is_word && idx == IDX_SP_PC) begin
               rsp_data_in.fall_through = 1'b0;
               if (is_write) sp_pc_in = wdata[11:0];
               else rsp_data_in.read_data = {20'd0, sp_pc_ff};
            end
         end
         UNIT_SI: begin
            if (is_word && is_write && idx == IDX_SI_STATUS) begin
               pending_in[INTR_SI]      = 1'b0;
               rsp_data_in.fall_through = 1'b0;
            end
         end
         UNIT_RDRAM: begin
            rsp_data_in.fall_through = init_mode_ff[RDRAM_REG_BIT];
         end
         default: begin
            rsp_data_in.fall_through = 1'b1;
         end
      endcase

      // Snapshot of held state after the access.
      rsp_data_in.pending_bits  = pending_in;
      rsp_data_in.mask_bits     = mask_in;
      rsp_data_in.sp_halted     = sp_status_in[0];
      rsp_data_in.dma_cart_addr = pi_cart_in;
      rsp_data_in.dma_dram_addr = pi_dram_in;
   end

   // State registers update only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_mode_ff <= '0;
         pending_ff   <= '0;
         mask_ff      <= '0;
         sp_status_ff <= '0;
         sema_ff      <= 1'b0;
         sp_pc_ff     <= '0;
         pi_dram_ff   <= '0;
         pi_cart_ff   <= '0;
      end else if (accept) begin
         init_mode_ff <= init_mode_in;
         pending_ff   <= pending_in;
         mask_ff      <= mask_in;
         sp_status_ff <= sp_status_in;
         sema_ff      <= sema_in;
         sp_pc_ff     <= sp_pc_in;
         pi_dram_ff   <= pi_dram_in;
         pi_cart_ff   <= pi_cart_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // A semaphore read always leaves the semaphore taken.
   a_sema_taken: assert property (@(posedge clock) disable iff (reset)
      (accept && unit == UNIT_SP && is_word && req_chan.data.mode == MODE_READ &&
       idx == IDX_SP_SEMA) |=> sema_ff)
      else $error("semaphore not set after test-and-set read");

   // A DMA start comes only from a good word access and serves memory as well.
   a_dma_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.dma_start) |->
      (!rsp_data_ff.bad_access && rsp_data_ff.fall_through &&
       rsp_data_ff.dma_length != 25'd0))
      else $error("inconsistent DMA start result");

   // A mask write is handled here and never passes to memory.
   a_mask_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.clear_cpu_mi_cause) |->
      (!rsp_data_ff.fall_through && !rsp_data_ff.bad_access))
      else $error("cause clear on an access that falls through");

   // Data returned by a modeled read never comes with a fall-through.
   a_read_owned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.read_data != 32'd0) |-> !rsp_data_ff.fall_through)
      else $error("read data on a fall-through access");

endmodule
